@@ hdl/arpc_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the ARP resolver.
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int PENDING_HOSTS = 8;
  localparam int HOLD_DEPTH    = 8;

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW  = (PENDING_HOSTS > 1) ? $clog2(PENDING_HOSTS) : 1;
  localparam int HIW  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HCW  = $clog2(HOLD_DEPTH + 1);
  localparam int HMW  = PIW + HIW;
  localparam int HMD  = 1 << HMW;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] RTO_RESET = 16'd5000;
  localparam logic [15:0] CLT_RESET = 16'd30000;

  localparam logic [1:0] FUNC_SEND  = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] FT_IPV4 = 2'd0;
  localparam logic [1:0] FT_ARP  = 2'd1;

  localparam logic [1:0] KIND_IPV4  = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_UP    = 2'd3;

  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_RTO     = 2'd2;
  localparam logic [1:0] REG_CLT     = 2'd3;

  typedef enum logic [2:0] {
    SEL_HIT, SEL_REQ, SEL_UP, SEL_FLUSH, SEL_REPLY
  } emit_sel_t;

  typedef enum logic [1:0] {
    FR_DROP, FR_IPV4, FR_ARP
  } frame_cls_t;

  typedef struct packed {
    logic      load;
    logic      c_step;
    logic      p_step;
    logic      c_tick;
    logic      p_tick;
    logic      learn_wr;
    logic      send_upd;
    logic      j_clr;
    logic      j_step;
    logic      retire;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    frame_cls_t cls;
    logic       c_done;
    logic       p_done;
    logic       c_hit;
    logic       p_match;
    logic       p_free;
    logic       req_needed;
    logic       is_req;
    logic       hc_zero;
    logic       j_final;
    logic       out_free;
  } sts_t;

endpackage

@@ hdl/arp_resolver_with_cache_unit.sv @@
// Top level of the ARP resolver with mapping cache: controller plus datapath.
//
// Channels: the input channel (in_valid/in_ready) takes one item per handshake:
// a send, a received frame or a time tick, selected by in_func. The result
// channel (out_valid/out_ready) gives zero to nine result items per input
// item; out_last marks the final one. The configuration channel
// (cfg_valid/cfg_ready, always ready) writes own MAC, own IP, request
// timeout and cache lifetime by cfg_index.
// Timing: one item is worked at a time. A send scans the cache, one entry a
// cycle, then on a miss the pending table, one entry a cycle. A received ARP
// frame scans both tables too, then reads the hold memory and emits a result
// for each flushed handle, one after the other. A tick sweeps the pending
// table, then the cache. The next item is accepted only once the controller
// is back in idle.
// Reset: synchronous, active low; clears all valid bits, counts and
// config registers (timeout 5000 ms, lifetime 30000 ms), no clearing pass.
// Stall: a result holds in the output register until taken; the next input
// item is accepted meanwhile, and its first result waits for that register.
module arp_resolver_with_cache_unit import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_datagram_handle,
  input  logic [15:0] in_elapsed_ms,
  input  logic [47:0] in_frame_dst_mac,
  input  logic [1:0]  in_frame_type,
  input  logic        in_parse_ok,
  input  logic        in_arp_is_request,
  input  logic [47:0] in_arp_sender_mac,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [31:0] in_arp_target_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_arp_target_mac_out,
  output logic [31:0] out_arp_target_ip_out,
  output logic [15:0] out_handle_out,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // the user must write registers only while idle (not enforced here), so take every write at once
  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arpc_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_func                (in_func),
    .in_next_hop_ip         (in_next_hop_ip),
    .in_datagram_handle     (in_datagram_handle),
    .in_elapsed_ms          (in_elapsed_ms),
    .in_frame_dst_mac       (in_frame_dst_mac),
    .in_frame_type          (in_frame_type),
    .in_parse_ok            (in_parse_ok),
    .in_arp_is_request      (in_arp_is_request),
    .in_arp_sender_mac      (in_arp_sender_mac),
    .in_arp_sender_ip       (in_arp_sender_ip),
    .in_arp_target_ip       (in_arp_target_ip),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_dest_mac           (out_dest_mac),
    .out_arp_target_mac_out (out_arp_target_mac_out),
    .out_arp_target_ip_out  (out_arp_target_ip_out),
    .out_handle_out         (out_handle_out),
    .out_last               (out_last)
  );

endmodule

@@ hdl/arpc_ctrl.sv @@
// Controller state machine that sequences scans, updates and result emission.
module arpc_ctrl import arpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISP     = 14'b00000000000010,
    S_CSCAN    = 14'b00000000000100,
    S_PSCAN    = 14'b00000000001000,
    S_SUPD     = 14'b00000000010000,
    S_EMIT_HIT = 14'b00000000100000,
    S_EMIT_REQ = 14'b00000001000000,
    S_EMIT_UP  = 14'b00000010000000,
    S_LWR      = 14'b00000100000000,
    S_FRD      = 14'b00001000000000,
    S_FEM      = 14'b00010000000000,
    S_REPLY    = 14'b00100000000000,
    S_TICKP    = 14'b01000000000000,
    S_TICKC    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_sel = SEL_HIT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FUNC_SEND: state_nxt = S_CSCAN;
          FUNC_FRAME: begin
            case (sts.cls)
              FR_IPV4: state_nxt = S_EMIT_UP;
              FR_ARP:  state_nxt = S_CSCAN;
              default: state_nxt = S_IDLE;
            endcase
          end
          FUNC_TICK: state_nxt = S_TICKP;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_CSCAN: begin
        if (!sts.c_done) begin
          cmd.c_step = 1'b1;
        end else if (sts.func == FUNC_SEND) begin
          state_nxt = sts.c_hit ? S_EMIT_HIT : S_PSCAN;
        end else begin
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        cmd.learn_wr = 1'b1;
        state_nxt    = S_PSCAN;
      end
      S_PSCAN: begin
        if (!sts.p_done) begin
          cmd.p_step = 1'b1;
        end else if (sts.func == FUNC_SEND) begin
          state_nxt = (sts.p_match || sts.p_free) ? S_SUPD : S_IDLE;
        end else if (sts.p_match && !sts.hc_zero) begin
          cmd.j_clr = 1'b1;
          state_nxt = S_FRD;
        end else begin
          cmd.retire = sts.p_match;
          state_nxt  = sts.is_req ? S_REPLY : S_IDLE;
        end
      end
      S_SUPD: begin
        cmd.send_upd = 1'b1;
        state_nxt    = sts.req_needed ? S_EMIT_REQ : S_IDLE;
      end
      S_EMIT_HIT, S_EMIT_REQ, S_EMIT_UP: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_sel  = (state_r == S_EMIT_HIT) ? SEL_HIT :
                          (state_r == S_EMIT_REQ) ? SEL_REQ : SEL_UP;
          state_nxt     = S_IDLE;
        end
      end
      S_FRD: begin
        state_nxt = S_FEM;
      end
      S_FEM: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_FLUSH;
          cmd.emit_last = sts.j_final && !sts.is_req;
          if (sts.j_final) begin
            cmd.retire = 1'b1;
            state_nxt  = sts.is_req ? S_REPLY : S_IDLE;
          end else begin
            cmd.j_step = 1'b1;
            state_nxt  = S_FRD;
          end
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_REPLY;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICKP: begin
        if (!sts.p_done) begin
          cmd.p_tick = 1'b1;
        end else begin
          state_nxt = S_TICKC;
        end
      end
      S_TICKC: begin
        if (!sts.c_done) begin
          cmd.c_tick = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/arpc_dp.sv @@
// Datapath: item and config registers, cache and pending tables, hold memory, result register.
module arpc_dp import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_datagram_handle,
  input  logic [15:0] in_elapsed_ms,
  input  logic [47:0] in_frame_dst_mac,
  input  logic [1:0]  in_frame_type,
  input  logic        in_parse_ok,
  input  logic        in_arp_is_request,
  input  logic [47:0] in_arp_sender_mac,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [31:0] in_arp_target_ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_arp_target_mac_out,
  output logic [31:0] out_arp_target_ip_out,
  output logic [15:0] out_handle_out,
  output logic        out_last
);

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [15:0] rto_r, clt_r;

  logic [1:0]  func_r, ftype_r;
  logic [31:0] ip_r, sip_r, tip_r;
  logic [15:0] handle_r, el_r;
  logic [47:0] dst_r, smac_r;
  logic        ok_r, isreq_r;

  logic        cache_valid_r [CACHE_ENTRIES];
  logic [31:0] cache_ip_r    [CACHE_ENTRIES];
  logic [47:0] cache_mac_r   [CACHE_ENTRIES];
  logic [15:0] cache_age_r   [CACHE_ENTRIES];
  logic        pend_valid_r  [PENDING_HOSTS];
  logic        req_act_r     [PENDING_HOSTS];
  logic [HCW-1:0] held_cnt_r [PENDING_HOSTS];
  logic [31:0] pend_ip_r     [PENDING_HOSTS];
  logic [15:0] req_age_r     [PENDING_HOSTS];
  logic [15:0] held_mem      [HMD];
  logic [15:0] held_q_r;

  logic [CIW:0]   cidx_r;
  logic [PIW:0]   pidx_r;
  logic [HCW-1:0] jdx_r;
  logic           c_hit_r, c_free_r, p_match_r, p_free_r;
  logic [CIW-1:0] c_hit_idx_r, c_free_idx_r;
  logic [PIW-1:0] p_m_idx_r, p_f_idx_r;
  logic           out_valid_r, out_last_r;
  logic [1:0]     out_kind_r;
  logic [47:0]    out_dmac_r, out_tmac_r;
  logic [31:0]    out_tip_r;
  logic [15:0]    out_h_r;

  logic [CIW-1:0] ce;
  logic [PIW-1:0] pe, ps;
  logic [31:0]    key;
  logic           c_eq, p_eq, addr_ok;
  logic [16:0]    c_sum, p_sum;
  logic           c_keep, p_keep;
  logic [HCW-1:0] hc_eff;
  logic           hold_wr;

  assign ce  = cidx_r[CIW-1:0];
  assign pe  = pidx_r[PIW-1:0];
  assign ps  = p_match_r ? p_m_idx_r : p_f_idx_r;
  assign key = (func_r == FUNC_SEND) ? ip_r : sip_r;
  assign c_eq = cache_valid_r[ce] && (cache_ip_r[ce] == key);
  assign p_eq = pend_valid_r[pe] && (pend_ip_r[pe] == key);
  assign c_sum  = {1'b0, cache_age_r[ce]} + {1'b0, el_r};
  assign p_sum  = {1'b0, req_age_r[pe]} + {1'b0, el_r};
  assign c_keep = (c_sum <= {1'b0, clt_r});
  assign p_keep = (p_sum <= {1'b0, rto_r});
  assign hc_eff = p_match_r ? held_cnt_r[ps] : '0;
  assign hold_wr = cmd.send_upd && (hc_eff < HCW'(HOLD_DEPTH));
  assign addr_ok = (dst_r == BCAST_MAC) || (dst_r == own_mac_r);

  always_comb begin
    sts = '0;
    sts.func = func_r;
    if (addr_ok && ok_r && ftype_r == FT_IPV4) begin
      sts.cls = FR_IPV4;
    end else if (addr_ok && ok_r && ftype_r == FT_ARP && tip_r == own_ip_r) begin
      sts.cls = FR_ARP;
    end else begin
      sts.cls = FR_DROP;
    end
    sts.c_done     = (cidx_r == (CIW+1)'(CACHE_ENTRIES));
    sts.p_done     = (pidx_r == (PIW+1)'(PENDING_HOSTS));
    sts.c_hit      = c_hit_r;
    sts.p_match    = p_match_r;
    sts.p_free     = p_free_r;
    sts.req_needed = !(p_match_r && req_act_r[ps]);
    sts.is_req     = isreq_r;
    sts.hc_zero    = (held_cnt_r[p_m_idx_r] == '0);
    sts.j_final    = (HCW'(jdx_r + 1'b1) == held_cnt_r[p_m_idx_r]);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // config and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
      rto_r     <= RTO_RESET;
      clt_r     <= CLT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_MAC: own_mac_r <= cfg_data;
        REG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
        REG_RTO:     rto_r     <= cfg_data[15:0];
        REG_CLT:     clt_r     <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      ip_r     <= in_next_hop_ip;
      handle_r <= in_datagram_handle;
      el_r     <= in_elapsed_ms;
      dst_r    <= in_frame_dst_mac;
      ftype_r  <= in_frame_type;
      ok_r     <= in_parse_ok;
      isreq_r  <= in_arp_is_request;
      smac_r   <= in_arp_sender_mac;
      sip_r    <= in_arp_sender_ip;
      tip_r    <= in_arp_target_ip;
    end
  end

  // scan counters and search results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cidx_r    <= '0;
      pidx_r    <= '0;
      jdx_r     <= '0;
      c_hit_r   <= 1'b0;
      c_free_r  <= 1'b0;
      p_match_r <= 1'b0;
      p_free_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        cidx_r    <= '0;
        pidx_r    <= '0;
        c_hit_r   <= 1'b0;
        c_free_r  <= 1'b0;
        p_match_r <= 1'b0;
        p_free_r  <= 1'b0;
      end
      if (cmd.c_step || cmd.c_tick) begin
        cidx_r <= cidx_r + 1'b1;
      end
      if (cmd.p_step || cmd.p_tick) begin
        pidx_r <= pidx_r + 1'b1;
      end
      if (cmd.c_step) begin
        if (c_eq && !c_hit_r) begin
          c_hit_r     <= 1'b1;
          c_hit_idx_r <= ce;
        end
        if (!cache_valid_r[ce] && !c_free_r) begin
          c_free_r     <= 1'b1;
          c_free_idx_r <= ce;
        end
      end
      if (cmd.p_step) begin
        if (p_eq && !p_match_r) begin
          p_match_r <= 1'b1;
          p_m_idx_r <= pe;
        end
        if (!pend_valid_r[pe] && !p_free_r) begin
          p_free_r  <= 1'b1;
          p_f_idx_r <= pe;
        end
      end
      if (cmd.j_clr) begin
        jdx_r <= '0;
      end else if (cmd.j_step) begin
        jdx_r <= jdx_r + 1'b1;
      end
    end
  end

  // cache table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) cache_valid_r[i] <= 1'b0;
    end else begin
      if (cmd.learn_wr && !c_hit_r && c_free_r) begin
        cache_valid_r[c_free_idx_r] <= 1'b1;
      end
      if (cmd.c_tick && cache_valid_r[ce] && !c_keep) begin
        cache_valid_r[ce] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.learn_wr) begin
      if (c_hit_r) begin
        cache_mac_r[c_hit_idx_r] <= smac_r;
        cache_age_r[c_hit_idx_r] <= '0;
      end else if (c_free_r) begin
        cache_ip_r[c_free_idx_r]  <= sip_r;
        cache_mac_r[c_free_idx_r] <= smac_r;
        cache_age_r[c_free_idx_r] <= '0;
      end
    end
    if (cmd.c_tick && cache_valid_r[ce] && c_keep) begin
      cache_age_r[ce] <= c_sum[15:0];
    end
  end

  // pending table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PENDING_HOSTS; i++) begin
        pend_valid_r[i] <= 1'b0;
        req_act_r[i]    <= 1'b0;
        held_cnt_r[i]   <= '0;
      end
    end else begin
      if (cmd.send_upd) begin
        pend_valid_r[ps] <= 1'b1;
        req_act_r[ps]    <= 1'b1;
        held_cnt_r[ps]   <= hold_wr ? HCW'(hc_eff + 1'b1) : hc_eff;
      end
      if (cmd.retire) begin
        pend_valid_r[p_m_idx_r] <= 1'b0;
        req_act_r[p_m_idx_r]    <= 1'b0;
        held_cnt_r[p_m_idx_r]   <= '0;
      end
      if (cmd.p_tick && pend_valid_r[pe] && req_act_r[pe] && !p_keep) begin
        req_act_r[pe] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_upd) begin
      if (!p_match_r) begin
        pend_ip_r[ps] <= ip_r;
      end
      if (sts.req_needed) begin
        req_age_r[ps] <= '0;
      end
    end
    if (cmd.p_tick && pend_valid_r[pe] && req_act_r[pe] && p_keep) begin
      req_age_r[pe] <= p_sum[15:0];
    end
  end

  // hold memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (hold_wr) begin
      held_mem[{ps, hc_eff[HIW-1:0]}] <= handle_r;
    end
    held_q_r <= held_mem[{p_m_idx_r, jdx_r[HIW-1:0]}];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.emit_last;
      out_dmac_r <= '0;
      out_tmac_r <= '0;
      out_tip_r  <= '0;
      out_h_r    <= '0;
      case (cmd.emit_sel)
        SEL_HIT: begin
          out_kind_r <= KIND_IPV4;
          out_dmac_r <= cache_mac_r[c_hit_idx_r];
          out_h_r    <= handle_r;
        end
        SEL_REQ: begin
          out_kind_r <= KIND_REQ;
          out_dmac_r <= BCAST_MAC;
          out_tip_r  <= ip_r;
        end
        SEL_UP: begin
          out_kind_r <= KIND_UP;
          out_h_r    <= handle_r;
        end
        SEL_FLUSH: begin
          out_kind_r <= KIND_IPV4;
          out_dmac_r <= smac_r;
          out_h_r    <= held_q_r;
        end
        SEL_REPLY: begin
          out_kind_r <= KIND_REPLY;
          out_dmac_r <= smac_r;
          out_tmac_r <= smac_r;
          out_tip_r  <= sip_r;
        end
        default: out_kind_r <= KIND_UP;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_dest_mac           = out_dmac_r;
  assign out_arp_target_mac_out = out_tmac_r;
  assign out_arp_target_ip_out  = out_tip_r;
  assign out_handle_out         = out_h_r;
  assign out_last               = out_last_r;

endmodule

@@ hdl/arpc_chk.sv @@
// Port-level checker for the ARP resolver and its bind to the top level.
module arpc_chk import arpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [47:0] out_dest_mac,
  input logic [47:0] out_arp_target_mac_out,
  input logic [31:0] out_arp_target_ip_out,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item still in work");

  a_req_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQ |-> out_dest_mac == BCAST_MAC && out_last &&
      out_arp_target_mac_out == '0)
    else $error("malformed ARP request result");

  a_up_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_UP |-> out_last && out_dest_mac == '0 &&
      out_arp_target_ip_out == '0)
    else $error("malformed delivered-up result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind arp_resolver_with_cache_unit arpc_chk u_arpc_chk (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_kind               (out_kind),
  .out_dest_mac           (out_dest_mac),
  .out_arp_target_mac_out (out_arp_target_mac_out),
  .out_arp_target_ip_out  (out_arp_target_ip_out),
  .out_last               (out_last)
);

@@ sim/arp_resolver_with_cache_unit_checker.sv @@
// Result predictor and scoreboard for the ARP resolver, watching all three channels.
module arp_resolver_with_cache_unit_checker import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_next_hop_ip,
  input  logic [15:0] in_datagram_handle,
  input  logic [15:0] in_elapsed_ms,
  input  logic [47:0] in_frame_dst_mac,
  input  logic [1:0]  in_frame_type,
  input  logic        in_parse_ok,
  input  logic        in_arp_is_request,
  input  logic [47:0] in_arp_sender_mac,
  input  logic [31:0] in_arp_sender_ip,
  input  logic [31:0] in_arp_target_ip,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [47:0] out_dest_mac,
  input  logic [47:0] out_arp_target_mac_out,
  input  logic [31:0] out_arp_target_ip_out,
  input  logic [15:0] out_handle_out,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dmac;
    logic [47:0] tmac;
    logic [31:0] tip;
    logic [15:0] hnd;
    logic        last;
  } arp_result_t;

  arp_result_t frames_due[$];

  logic [47:0] my_mac;
  logic [31:0] my_ip;
  logic [15:0] req_life, map_life;

  logic        map_v   [CACHE_ENTRIES];
  logic [31:0] map_ip  [CACHE_ENTRIES];
  logic [47:0] map_mac [CACHE_ENTRIES];
  logic [15:0] map_age [CACHE_ENTRIES];
  logic        host_v  [PENDING_HOSTS];
  logic [31:0] host_ip [PENDING_HOSTS];
  logic        asking  [PENDING_HOSTS];
  logic [15:0] ask_age [PENDING_HOSTS];
  logic [15:0] parked  [PENDING_HOSTS][HOLD_DEPTH];
  int          n_parked[PENDING_HOSTS];

  assign waiting = frames_due.size();

  function automatic arp_result_t mk(logic [1:0] k, logic [47:0] d, logic [47:0] t,
                                     logic [31:0] ip, logic [15:0] h);
    arp_result_t r;
    r = '{kind: k, dmac: d, tmac: t, tip: ip, hnd: h, last: 1'b0};
    return r;
  endfunction

  function automatic int host_slot(logic [31:0] ip);
    for (int i = 0; i < PENDING_HOSTS; i++)
      if (host_v[i] && host_ip[i] == ip) return i;
    return -1;
  endfunction

  // Work out the results of one accepted item and advance the tables.
  task automatic resolve_item();
    arp_result_t got[$];
    int p, f;
    logic hit;
    hit = 1'b0;
    case (in_func)
      FUNC_SEND: begin
        for (int i = 0; i < CACHE_ENTRIES && !hit; i++)
          if (map_v[i] && map_ip[i] == in_next_hop_ip) begin
            got.push_back(mk(KIND_IPV4, map_mac[i], '0, '0, in_datagram_handle));
            hit = 1'b1;
          end
        if (!hit) begin
          p = host_slot(in_next_hop_ip);
          if (p < 0) begin
            for (int i = 0; i < PENDING_HOSTS && p < 0; i++)
              if (!host_v[i]) p = i;
            if (p >= 0) begin
              host_v[p] = 1'b1;
              host_ip[p] = in_next_hop_ip;
              asking[p] = 1'b0;
              ask_age[p] = '0;
              n_parked[p] = 0;
            end
          end
          // full pending table: drop silently
          if (p >= 0) begin
            if (n_parked[p] < HOLD_DEPTH) begin
              parked[p][n_parked[p]] = in_datagram_handle;
              n_parked[p]++;
            end
            if (!asking[p]) begin
              asking[p] = 1'b1;
              ask_age[p] = '0;
              got.push_back(mk(KIND_REQ, BCAST_MAC, '0, in_next_hop_ip, '0));
            end
          end
        end
      end
      FUNC_FRAME: begin
        if (in_frame_dst_mac == BCAST_MAC || in_frame_dst_mac == my_mac) begin
          if (in_frame_type == FT_IPV4) begin
            if (in_parse_ok) got.push_back(mk(KIND_UP, '0, '0, '0, in_datagram_handle));
          end else if (in_frame_type == FT_ARP && in_parse_ok &&
                       in_arp_target_ip == my_ip) begin
            // learn: refresh an existing mapping, else take the first free entry
            f = -1;
            for (int i = 0; i < CACHE_ENTRIES && !hit; i++) begin
              if (map_v[i] && map_ip[i] == in_arp_sender_ip) begin
                map_mac[i] = in_arp_sender_mac;
                map_age[i] = '0;
                hit = 1'b1;
              end else if (!map_v[i] && f < 0) f = i;
            end
            if (!hit && f >= 0) begin
              map_v[f] = 1'b1;
              map_ip[f] = in_arp_sender_ip;
              map_mac[f] = in_arp_sender_mac;
              map_age[f] = '0;
            end
            p = host_slot(in_arp_sender_ip);
            if (p >= 0) begin
              for (int j = 0; j < n_parked[p]; j++)
                got.push_back(mk(KIND_IPV4, in_arp_sender_mac, '0, '0, parked[p][j]));
              host_v[p] = 1'b0;
              asking[p] = 1'b0;
              n_parked[p] = 0;
            end
            if (in_arp_is_request)
              got.push_back(mk(KIND_REPLY, in_arp_sender_mac, in_arp_sender_mac,
                               in_arp_sender_ip, '0));
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < PENDING_HOSTS; i++)
          if (host_v[i] && asking[i]) begin
            if (17'(ask_age[i]) + 17'(in_elapsed_ms) <= 17'(req_life))
              ask_age[i] = ask_age[i] + in_elapsed_ms;
            else asking[i] = 1'b0;
          end
        for (int i = 0; i < CACHE_ENTRIES; i++)
          if (map_v[i]) begin
            if (17'(map_age[i]) + 17'(in_elapsed_ms) <= 17'(map_life))
              map_age[i] = map_age[i] + in_elapsed_ms;
            else map_v[i] = 1'b0;
          end
      end
      default: ;
    endcase
    if (got.size() > 0) got[got.size() - 1].last = 1'b1;
    foreach (got[k]) frames_due.push_back(got[k]);
  endtask

  always @(posedge clk) begin
    arp_result_t exp_r, act_r;
    if (!rst_n) begin
      my_mac = '0;
      my_ip = '0;
      req_life = RTO_RESET;
      map_life = CLT_RESET;
      for (int i = 0; i < CACHE_ENTRIES; i++) map_v[i] = 1'b0;
      for (int i = 0; i < PENDING_HOSTS; i++) begin
        host_v[i] = 1'b0;
        asking[i] = 1'b0;
        n_parked[i] = 0;
      end
      frames_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        act_r = '{out_kind, out_dest_mac, out_arp_target_mac_out, out_arp_target_ip_out,
                  out_handle_out, out_last};
        if (frames_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("[%0t] result with nothing expected: %h", $time, act_r);
        end else begin
          exp_r = frames_due.pop_front();
          if (exp_r !== act_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch kind %0d/%0d dmac %h/%h tmac %h/%h tip %h/%h h %h/%h last %b/%b",
                       $time, exp_r.kind, act_r.kind, exp_r.dmac, act_r.dmac, exp_r.tmac,
                       act_r.tmac, exp_r.tip, act_r.tip, exp_r.hnd, act_r.hnd, exp_r.last,
                       act_r.last);
          end
        end
      end
      if (in_valid && in_ready) resolve_item();
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_OWN_MAC: my_mac = cfg_data;
          REG_OWN_IP:  my_ip = cfg_data[31:0];
          REG_RTO:     req_life = cfg_data[15:0];
          REG_CLT:     map_life = cfg_data[15:0];
          default:     ;
        endcase
    end
  end

  initial fail_count = 0;
endmodule

@@ sim/arp_resolver_with_cache_unit_tb.sv @@
// Stimulus, clocking and verdict for the ARP resolver testbench.
module arp_resolver_with_cache_unit_tb;
  import arpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 60;   // longer than a full table sweep

  typedef struct {
    logic [1:0]  func;
    logic [31:0] nh_ip;
    logic [15:0] handle;
    logic [15:0] elapsed;
    logic [47:0] dst;
    logic [1:0]  ftype;
    logic        ok;
    logic        isreq;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
  } arp_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [31:0] in_next_hop_ip = '0;
  logic [15:0] in_datagram_handle = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic [47:0] in_frame_dst_mac = '0;
  logic [1:0]  in_frame_type = '0;
  logic        in_parse_ok = 1'b0;
  logic        in_arp_is_request = 1'b0;
  logic [47:0] in_arp_sender_mac = '0;
  logic [31:0] in_arp_sender_ip = '0;
  logic [31:0] in_arp_target_ip = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [47:0] out_dest_mac;
  logic [47:0] out_arp_target_mac_out;
  logic [31:0] out_arp_target_ip_out;
  logic [15:0] out_handle_out;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  int fail_count, waiting;
  int items_sent = 0, results_seen = 0, quiet = 0;
  logic bubbles = 1'b1;   // random idling on both sides when set

  logic [47:0] host_mac;
  logic [31:0] host_ip;
  logic [31:0] peer_base;  // small pool of peers so tables fill and hit

  arp_resolver_with_cache_unit dut (.*);

  arp_resolver_with_cache_unit_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, or never during the calm phase.
  always @(negedge clk) out_ready = !bubbles || ($urandom_range(0, 99) >= 34);

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired after %0d quiet cycles", quiet);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item at a falling edge and hold it until taken.
  task automatic drive(input arp_item_t it);
    while (bubbles && $urandom_range(0, 99) < 34) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = it.func;
    in_next_hop_ip = it.nh_ip;
    in_datagram_handle = it.handle;
    in_elapsed_ms = it.elapsed;
    in_frame_dst_mac = it.dst;
    in_frame_type = it.ftype;
    in_parse_ok = it.ok;
    in_arp_is_request = it.isreq;
    in_arp_sender_mac = it.smac;
    in_arp_sender_ip = it.sip;
    in_arp_target_ip = it.tip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Fill every field with noise, then callers overwrite what matters.
  function automatic arp_item_t noise();
    arp_item_t it;
    it.func = 2'($urandom);
    it.nh_ip = $urandom;
    it.handle = 16'($urandom);
    it.elapsed = 16'($urandom);
    it.dst = {16'($urandom), 32'($urandom)};
    it.ftype = 2'($urandom);
    it.ok = 1'($urandom);
    it.isreq = 1'($urandom);
    it.smac = {16'($urandom), 32'($urandom)};
    it.sip = $urandom;
    it.tip = $urandom;
    return it;
  endfunction

  task automatic send(input logic [31:0] ip, input logic [15:0] h);
    arp_item_t it;
    it = noise();
    it.func = FUNC_SEND;
    it.nh_ip = ip;
    it.handle = h;
    drive(it);
  endtask

  task automatic arp_in(input logic [47:0] dst, input logic isreq, input logic [47:0] smac,
                        input logic [31:0] sip, input logic [31:0] tip);
    arp_item_t it;
    it = noise();
    it.func = FUNC_FRAME;
    it.dst = dst;
    it.ftype = FT_ARP;
    it.ok = 1'b1;
    it.isreq = isreq;
    it.smac = smac;
    it.sip = sip;
    it.tip = tip;
    drive(it);
  endtask

  task automatic tick(input logic [15:0] ms);
    arp_item_t it;
    it = noise();
    it.func = FUNC_TICK;
    it.elapsed = ms;
    drive(it);
  endtask

  task automatic ipv4_in(input logic [47:0] dst, input logic ok, input logic [15:0] h);
    arp_item_t it;
    it = noise();
    it.func = FUNC_FRAME;
    it.dst = dst;
    it.ftype = FT_IPV4;
    it.ok = ok;
    it.handle = h;
    drive(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the sender until every result is out and the block has gone quiet.
  task automatic drain();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_regs(input logic [47:0] mac, input logic [31:0] ip,
                          input logic [15:0] rto, input logic [15:0] clt);
    drain();
    host_mac = mac;
    host_ip = ip;
    write_reg(REG_OWN_MAC, mac);
    write_reg(REG_OWN_IP, {16'd0, ip});
    write_reg(REG_RTO, {32'd0, rto});
    write_reg(REG_CLT, {32'd0, clt});
  endtask

  function automatic logic [31:0] peer();
    return peer_base + $urandom_range(0, 23);
  endfunction

  function automatic logic [47:0] frame_dst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return host_mac;
    if (r < 90) return BCAST_MAC;
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly well-formed traffic around the peer pool, with some noise mixed in.
  task automatic random_phase(input int count);
    arp_item_t it;
    int r;
    logic [15:0] ms;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 42) send(peer(), 16'($urandom));
      else if (r < 68)
        arp_in(frame_dst(), 1'($urandom), {16'($urandom), 32'($urandom)}, peer(),
               ($urandom_range(0, 99) < 85) ? host_ip : $urandom);
      else if (r < 80) begin
        r = $urandom_range(0, 99);
        ms = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : 16'($urandom_range(0, 3000));
        tick(ms);
      end else if (r < 88) ipv4_in(frame_dst(), 1'($urandom), 16'($urandom));
      else begin
        it = noise();
        drive(it);
      end
    end
  endtask

  initial begin
    arp_item_t it;
    peer_base = $urandom & 32'hFFFF_FF00;
    host_mac = '0;
    host_ip = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: defaults first, then a known identity.
    send(peer_base, 16'h0000);
    set_regs(48'h0200_1234_5678, 32'hC0A8_0001, 16'd5000, 16'd30000);
    send(32'h0A00_0001, 16'hFFFF);            // miss, request goes out
    send(32'h0A00_0001, 16'h1111);            // held, request outstanding
    arp_in(host_mac, 1'b0, 48'hAAAA_0000_0001, 32'h0A00_0001, host_ip); // flush two
    send(32'h0A00_0001, 16'h2222);            // cache hit
    arp_in(BCAST_MAC, 1'b1, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF, host_ip); // reply only
    ipv4_in(host_mac, 1'b1, 16'hABCD);        // delivered up
    ipv4_in(BCAST_MAC, 1'b0, 16'h1234);       // parse failure
    ipv4_in(48'h0000_0000_0001, 1'b1, 16'h5555); // not for us
    it = noise(); it.func = FUNC_FRAME; it.dst = host_mac; it.ftype = 2'd2; it.ok = 1'b1;
    drive(it);                                // other ethertype
    arp_in(host_mac, 1'b1, 48'h1, 32'h1, host_ip ^ 32'h1); // target not ours
    it = noise(); it.func = 2'd3; drive(it); // unused function
    tick(16'd0);
    // Hold queue overflow, then an ARP request flushes eight and replies.
    for (int k = 0; k < 9; k++) send(32'h0B00_0000, 16'(k));
    arp_in(host_mac, 1'b1, 48'hBEEF_0000_0002, 32'h0B00_0000, host_ip);
    tick(16'hFFFF);                           // ages everything out
    send(32'h0A00_0001, 16'h3333);            // mapping gone: new request

    // Random phases across register settings, the extremes among them.
    set_regs({16'($urandom), 32'($urandom)}, $urandom, 16'd5000, 16'd30000);
    random_phase(110);
    set_regs(BCAST_MAC, 32'hFFFF_FFFF, 16'd1, 16'd1);
    random_phase(90);
    bubbles = 1'b0;                           // calm stretch: no idling at all
    set_regs(48'd0, 32'd0, 16'hFFFF, 16'hFFFF);
    random_phase(100);
    bubbles = 1'b1;
    set_regs({16'($urandom), 32'($urandom)}, $urandom, 16'($urandom_range(1, 4000)),
             16'($urandom_range(1, 9000)));
    random_phase(110);
    set_regs(48'h0123_4567_89AB, 32'h7F00_0001, 16'd2000, 16'd65535);
    random_phase(90);

    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d items through five register settings and got %0d results,",
             items_sent, results_seen);
    $display("covering sends, ARP learning and flushes, IPv4 delivery, ticks and noise.");
    if (fail_count == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ arp_resolver_with_cache_unit.f @@
hdl/arpc_pkg.sv
hdl/arpc_ctrl.sv
hdl/arpc_dp.sv
hdl/arp_resolver_with_cache_unit.sv
hdl/arpc_chk.sv
sim/arp_resolver_with_cache_unit_checker.sv
sim/arp_resolver_with_cache_unit_tb.sv
